FILE: design/tfma_pkg.sv
// Shared types and constants for the thermocouple frame moving-average block.
// No dependencies; used by tfma_ring and thermocouple_frame_moving_average.
package tfma_pkg;

  // Width of one temperature value in 1/20 degree Fahrenheit.
  localparam int unsigned SampleW = 18;

  typedef logic signed [SampleW-1:0] f20_t;

  // Status codes reported with every result.
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_XFER_FAIL = 2'd1;
  localparam status_t STATUS_FAULT     = 2'd2;

  // Converter frame layout.
  localparam int unsigned FaultBitPos = 16;
  localparam int unsigned TempMsb     = 31;
  localparam int unsigned TempLsb     = 18;
  localparam int unsigned TempW       = TempMsb - TempLsb + 1;

  // f20 = c*9 + 640, where c is quarter degrees Celsius.
  localparam f20_t F20Offset = 18'sd640;

  // Magnitude of the smallest f20 value; biases the running sum non-negative.
  localparam int unsigned F20Bias = 73088;

  // Ring access controls for one cycle.
  typedef struct packed {
    logic rd;  // read the slot at the write pointer and advance it
    logic wr;  // write the new sample into the slot of the last read
  } ring_ctl_t;

endpackage

FILE: design/tfma_ring.sv
// Sample history ring: synchronous memory with write pointer and fill flag.
// Depends on tfma_pkg for the sample type and the access control struct.
module tfma_ring #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfma_pkg::ring_ctl_t ctl_i,
  input  tfma_pkg::f20_t      wr_data_i,
  output tfma_pkg::f20_t      old_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tfma_pkg::f20_t mem [DEPTH];
  tfma_pkg::f20_t rd_data_q;
  logic [AW-1:0]  widx_q, widx_d;
  logic [AW-1:0]  wr_addr_q;
  logic           filled_q, filled_d;
  logic           old_valid_q;

  always_comb begin
    widx_d   = widx_q;
    filled_d = filled_q;
    if (ctl_i.rd) begin
      if (widx_q == AW'(DEPTH - 1)) begin
        widx_d   = '0;
        filled_d = 1'b1;
      end else begin
        widx_d = widx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q      <= '0;
      filled_q    <= 1'b0;
      old_valid_q <= 1'b0;
      wr_addr_q   <= '0;
    end else begin
      widx_q   <= widx_d;
      filled_q <= filled_d;
      if (ctl_i.rd) begin
        old_valid_q <= filled_q;
        wr_addr_q   <= widx_q;
      end
    end
  end

  // Slots not yet written since reset read as zero.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[wr_addr_q] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem[widx_q];
    end
  end

  assign old_o = old_valid_q ? rd_data_q : '0;

endmodule

FILE: design/thermocouple_frame_moving_average.sv
// Top level: thermocouple converter frame decode with moving average.
// Depends on tfma_pkg and tfma_ring.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o | raw_frame_i, transfer_ok_i
//  out     | output    | out_valid_o/out_stall_i | status_o, fault_*_o, sample_f20_o,
//          |           |                         | average_f20_o
//
// One transfer in per cycle unless out_stall_i backs up the pipeline, one result per transfer;
// stages: ring read, sum update and write back, reciprocal multiply, average and output register.
// The ring memory read port and the running-sum register set this stage split.
// Reset clears pointer, fill flag and all valid flags and sets the sum to its bias; unwritten slots read as zero.
// Each stage holds only while the stage after it is full and held, so bubbles close up
// under out_stall_i and input is taken until every stage is full.
module thermocouple_frame_moving_average #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [31:0]             raw_frame_i,
  input  logic                    transfer_ok_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic                    fault_short_vcc_o,
  output logic                    fault_short_gnd_o,
  output logic                    fault_open_o,
  output logic signed [17:0]      sample_f20_o,
  output logic signed [17:0]      average_f20_o
);

  localparam int unsigned SW = tfma_pkg::SampleW;
  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  // Biased running sum stays in [0, 2^(SW+AW)).
  localparam int unsigned SUMW = SW + AW;
  // floor(x / WINDOW_DEPTH) = (x * MUL) >> SH, exact for every x below 2^SUMW.
  localparam int unsigned SH   = SUMW + AW;
  localparam int unsigned MW   = SUMW + 1;
  localparam int unsigned PW   = SUMW + MW;
  localparam longint unsigned MulL =
    ((64'd1 << SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [MW-1:0]   MulC    = MW'(MulL);
  localparam logic [SUMW-1:0] SumBias = SUMW'(64'(tfma_pkg::F20Bias) * 64'(WINDOW_DEPTH));

  typedef logic signed [SUMW+1:0] sum_ext_t;

  // Stage advance chain: a stage moves when it is empty or its successor moves.
  logic adv_out, adv3, adv2, adv1;
  logic accept;

  // Stage 1: decoded item, ring read in flight.
  logic               s1_v_q;
  logic               s1_smp_q;
  tfma_pkg::status_t  s1_st_q;
  logic [2:0]         s1_flt_q;
  tfma_pkg::f20_t     s1_f20_q;

  // Stage 2: biased sum after this item.
  logic               s2_v_q;
  tfma_pkg::status_t  s2_st_q;
  logic [2:0]         s2_flt_q;
  tfma_pkg::f20_t     s2_f20_q;
  logic [SUMW-1:0]    s2_x_q;

  // Stage 3: reciprocal product.
  logic               s3_v_q;
  tfma_pkg::status_t  s3_st_q;
  logic [2:0]         s3_flt_q;
  tfma_pkg::f20_t     s3_f20_q;
  logic [PW-1:0]      s3_prod_q;

  // Output register.
  logic               out_v_q;
  tfma_pkg::status_t  out_st_q;
  logic [2:0]         out_flt_q;
  tfma_pkg::f20_t     out_f20_q;
  tfma_pkg::f20_t     out_avg_q;

  logic [SUMW-1:0]    sum_q, sum_d;

  assign adv_out    = !out_v_q || !out_stall_i;
  assign adv3       = !s3_v_q || adv_out;
  assign adv2       = !s2_v_q || adv3;
  assign adv1       = !s1_v_q || adv2;
  assign in_stall_o = !adv1;
  assign accept     = in_valid_i && adv1;

  // Decode the frame.
  logic                             fault_bit;
  logic                             is_sample;
  tfma_pkg::status_t                dec_st;
  logic [2:0]                       dec_flt;
  logic signed [tfma_pkg::TempW-1:0] celsius_q4;
  tfma_pkg::f20_t                   celsius_ext;
  tfma_pkg::f20_t                   dec_f20;

  assign fault_bit   = raw_frame_i[tfma_pkg::FaultBitPos];
  assign is_sample   = transfer_ok_i && !fault_bit;
  assign celsius_q4  = $signed(raw_frame_i[tfma_pkg::TempMsb:tfma_pkg::TempLsb]);
  assign celsius_ext = tfma_pkg::f20_t'(celsius_q4);

  always_comb begin
    dec_st  = tfma_pkg::STATUS_OK;
    dec_flt = 3'b000;
    dec_f20 = (celsius_ext <<< 3) + celsius_ext + tfma_pkg::F20Offset;
    if (!transfer_ok_i) begin
      dec_st  = tfma_pkg::STATUS_XFER_FAIL;
      dec_f20 = '0;
    end else if (fault_bit) begin
      dec_st  = tfma_pkg::STATUS_FAULT;
      dec_flt = raw_frame_i[2:0];
      dec_f20 = '0;
    end
  end

  // Ring: read the oldest sample when a sample is accepted, write the new one as it leaves stage 1.
  tfma_pkg::ring_ctl_t ring_ctl;
  tfma_pkg::f20_t      ring_old;

  assign ring_ctl.rd = accept && is_sample;
  assign ring_ctl.wr = s1_v_q && s1_smp_q && adv2;

  tfma_ring #(
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ring_ctl),
    .wr_data_i (s1_f20_q),
    .old_o     (ring_old)
  );

  // Replace the oldest sample in the running sum.
  sum_ext_t sum_ext;

  assign sum_ext = $signed({2'b00, sum_q}) - sum_ext_t'(ring_old) + sum_ext_t'(s1_f20_q);

  always_comb begin
    sum_d = sum_q;
    if (s1_smp_q) begin
      sum_d = sum_ext[SUMW-1:0];
    end
  end

  // Average: drop the bias after the reciprocal multiply.
  logic [SW-1:0]   quot;
  logic signed [SW:0] avg_ext;

  assign quot    = s3_prod_q[SH +: SW];
  assign avg_ext = $signed({1'b0, quot}) - $signed((SW+1)'(tfma_pkg::F20Bias));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      sum_q   <= SumBias;
    end else begin
      if (adv1) begin
        s1_v_q <= in_valid_i;
      end
      if (adv2) begin
        s2_v_q <= s1_v_q;
        if (s1_v_q) begin
          sum_q <= sum_d;
        end
      end
      if (adv3) begin
        s3_v_q <= s2_v_q;
      end
      if (adv_out) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  // Payload: load on advance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_smp_q <= is_sample;
      s1_st_q  <= dec_st;
      s1_flt_q <= dec_flt;
      s1_f20_q <= dec_f20;
    end
    if (adv2 && s1_v_q) begin
      s2_st_q  <= s1_st_q;
      s2_flt_q <= s1_flt_q;
      s2_f20_q <= s1_f20_q;
      s2_x_q   <= sum_d;
    end
    if (adv3 && s2_v_q) begin
      s3_st_q   <= s2_st_q;
      s3_flt_q  <= s2_flt_q;
      s3_f20_q  <= s2_f20_q;
      s3_prod_q <= PW'(s2_x_q) * PW'(MulC);
    end
    if (adv_out && s3_v_q) begin
      out_st_q  <= s3_st_q;
      out_flt_q <= s3_flt_q;
      out_f20_q <= s3_f20_q;
      out_avg_q <= avg_ext[SW-1:0];
    end
  end

  assign out_valid_o       = out_v_q;
  assign status_o          = out_st_q;
  assign fault_short_vcc_o = out_flt_q[2];
  assign fault_short_gnd_o = out_flt_q[1];
  assign fault_open_o      = out_flt_q[0];
  assign sample_f20_o      = out_f20_q;
  assign average_f20_o     = out_avg_q;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for thermocouple_frame_moving_average.
// Depends on tfma_pkg and the block itself; a scoreboard class predicts each reading.
module tb_top;

  localparam int unsigned Depth      = 8;     // moving-average window of the block
  localparam int unsigned QuietLimit = 4000;  // cycles with no transfer before giving up
  localparam int unsigned HoldCycles = 300;   // long receiver hold-off
  localparam int unsigned HoldAt     = 1100;  // frames taken before the hold starts
  localparam int unsigned DrainWait  = 8;     // pipeline is four stages deep

  // One result of the block, field by field.
  typedef struct {
    tfma_pkg::status_t status;
    logic              short_vcc;
    logic              short_gnd;
    logic              open_tc;
    tfma_pkg::f20_t    sample;
    tfma_pkg::f20_t    average;
  } reading_t;

  // Tracks the window, running sum and the readings still owed by the block.
  class reading_scoreboard;
    int          window_f20[Depth];
    int unsigned next_slot;
    longint      window_sum;
    reading_t    expected_readings[$];
    int unsigned n_frames;
    int unsigned errors;

    function new();
      foreach (window_f20[i]) window_f20[i] = 0;
      next_slot  = 0;
      window_sum = 0;
      n_frames   = 0;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // Work out the reading for one accepted frame and queue it.
    function void note_frame(logic [31:0] frame, logic ok);
      reading_t         r;
      logic signed [13:0] quarter_c;
      int               f20;
      longint           avg;
      r.status    = tfma_pkg::STATUS_OK;
      r.short_vcc = 1'b0;
      r.short_gnd = 1'b0;
      r.open_tc   = 1'b0;
      r.sample    = '0;
      n_frames++;
      if (!ok) begin
        r.status = tfma_pkg::STATUS_XFER_FAIL;
      end else if (frame[tfma_pkg::FaultBitPos]) begin
        r.status    = tfma_pkg::STATUS_FAULT;
        r.short_vcc = frame[2];
        r.short_gnd = frame[1];
        r.open_tc   = frame[0];
      end else begin
        quarter_c  = frame[tfma_pkg::TempMsb:tfma_pkg::TempLsb];
        f20        = int'(quarter_c) * 9 + 640;
        window_sum = window_sum - window_f20[next_slot] + f20;
        window_f20[next_slot] = f20;
        next_slot  = (next_slot == Depth - 1) ? 0 : next_slot + 1;
        r.sample   = tfma_pkg::f20_t'(f20);
      end
      // Floor division: round toward minus infinity on a negative sum.
      avg = window_sum / longint'(Depth);
      if (window_sum < 0 && (window_sum % longint'(Depth)) != 0) avg = avg - 1;
      r.average = tfma_pkg::f20_t'(avg);
      expected_readings.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expected reading.
    task check_reading(reading_t got);
      reading_t exp_r;
      if (expected_readings.size() == 0) begin
        report("result with no expected reading");
      end else begin
        exp_r = expected_readings.pop_front();
        if (got.status !== exp_r.status)
          report($sformatf("status got %0d want %0d", got.status, exp_r.status));
        if (got.short_vcc !== exp_r.short_vcc)
          report($sformatf("fault_short_vcc got %b want %b", got.short_vcc, exp_r.short_vcc));
        if (got.short_gnd !== exp_r.short_gnd)
          report($sformatf("fault_short_gnd got %b want %b", got.short_gnd, exp_r.short_gnd));
        if (got.open_tc !== exp_r.open_tc)
          report($sformatf("fault_open got %b want %b", got.open_tc, exp_r.open_tc));
        if (got.sample !== exp_r.sample)
          report($sformatf("sample_f20 got %0d want %0d", got.sample, exp_r.sample));
        if (got.average !== exp_r.average)
          report($sformatf("average_f20 got %0d want %0d", got.average, exp_r.average));
      end
    endtask
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [31:0]        raw_frame_i   = '0;
  logic               transfer_ok_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [1:0]         status_o;
  logic               fault_short_vcc_o;
  logic               fault_short_gnd_o;
  logic               fault_open_o;
  logic signed [17:0] sample_f20_o;
  logic signed [17:0] average_f20_o;

  reading_scoreboard sb;

  // Idle rates in percent; the stimulus process moves through the phases.
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 82;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned quiet_cycles  = 0;

  thermocouple_frame_moving_average #(
    .WINDOW_DEPTH(Depth)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_frame_i      (raw_frame_i),
    .transfer_ok_i    (transfer_ok_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .fault_short_vcc_o(fault_short_vcc_o),
    .fault_short_gnd_o(fault_short_gnd_o),
    .fault_open_o     (fault_open_o),
    .sample_f20_o     (sample_f20_o),
    .average_f20_o    (average_f20_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Build a frame around a temperature field, fault bit and low fault bits;
  // bit 17 and bits 15..3 carry random filler.
  function automatic logic [31:0] make_frame(logic [13:0] temp, logic fault, logic [2:0] low);
    logic [31:0] frame;
    frame                                      = $urandom;
    frame[tfma_pkg::TempMsb:tfma_pkg::TempLsb] = temp;
    frame[tfma_pkg::FaultBitPos]               = fault;
    frame[2:0]                                 = low;
    return frame;
  endfunction

  // Offer one frame, idling first at the current rate, and hold it until the transfer.
  task send_frame(logic [31:0] frame, logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    raw_frame_i   <= frame;
    transfer_ok_i <= ok;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_frame(frame, ok);
  endtask

  // Receiver: check every result transfer, then pick the next stall value.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      reading_t got;
      got.status    = status_o;
      got.short_vcc = fault_short_vcc_o;
      got.short_gnd = fault_short_gnd_o;
      got.open_tc   = fault_open_o;
      got.sample    = sample_f20_o;
      got.average   = average_f20_o;
      sb.check_reading(got);
    end
    if (hold_left != 0) begin
      // Keep holding off so the pipeline fills and backs up into the input.
      hold_left    = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && sb != null && sb.n_frames >= HoldAt) begin
      hold_done    = 1'b1;
      hold_left    = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: stop a run that makes no progress on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    int unsigned sel;
    logic [13:0] temp;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: failed transfer straight after reset, whatever the frame holds.
    send_frame(make_frame(14'h1FFF, 1'b0, 3'b000), 1'b0);
    send_frame(32'hFFFF_FFFF, 1'b0);
    send_frame(32'h0000_0000, 1'b0);
    // Sensor fault with each low fault bit, none and all.
    send_frame(make_frame(14'h0000, 1'b1, 3'b000), 1'b1);
    send_frame(make_frame(14'h1FFF, 1'b1, 3'b111), 1'b1);
    send_frame(make_frame(14'h2000, 1'b1, 3'b001), 1'b1);
    send_frame(make_frame(14'h0ABC, 1'b1, 3'b010), 1'b1);
    send_frame(make_frame(14'h3FFF, 1'b1, 3'b100), 1'b1);
    send_frame(32'hFFFF_FFFF, 1'b1);
    // Fault bit clear with low fault bits set: accepted, faults read zero.
    send_frame(make_frame(14'h0000, 1'b0, 3'b111), 1'b1);
    // Temperature extremes and values around zero.
    send_frame(make_frame(14'h1FFF, 1'b0, 3'b000), 1'b1);
    send_frame(make_frame(14'h2000, 1'b0, 3'b000), 1'b1);
    send_frame(make_frame(14'h3FFF, 1'b0, 3'b101), 1'b1);
    send_frame(make_frame(14'h0001, 1'b0, 3'b010), 1'b1);
    // Run of coldest readings: drive the sum negative and wrap the ring.
    for (i = 0; i < 10; i++) send_frame(make_frame(14'h2000, 1'b0, 3'($urandom)), 1'b1);
    // Average must stay put across a failed transfer.
    send_frame($urandom, 1'b0);

    // Random: mostly good samples, some failed transfers and sensor faults.
    for (i = 0; i < 1425; i++) begin
      if (i == 475) begin
        send_idle_pct = 82;
        recv_idle_pct = 8;
      end else if (i == 950) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sel = $urandom_range(99);
      if (sel < 12) begin
        send_frame($urandom, 1'b0);
      end else if (sel < 25) begin
        send_frame(make_frame(14'($urandom), 1'b1, 3'($urandom)), 1'b1);
      end else begin
        case ($urandom_range(3))
          0, 1:    temp = 14'($urandom);
          2:       temp = 14'h1FFF - 14'($urandom_range(15));
          default: temp = 14'h2000 + 14'($urandom_range(15));
        endcase
        send_frame(make_frame(temp, 1'b0, 3'($urandom)), 1'b1);
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every owed reading, then wait on for strays.
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.expected_readings.size() != 0) sb.report("expected reading never arrived");

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
